FILE: src/saturating_integer_alu_unit_defines.svh
// Assertion macros shared by the saturating ALU modules.
// Depends on nothing; the module that uses them provides clk and rst.
`ifndef SATURATING_INTEGER_ALU_UNIT_DEFINES_SVH
`define SATURATING_INTEGER_ALU_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SAI_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, when true, forces another one in the next cycle.
`define SAI_CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/sai_pkg.sv
// Shared types and constants for the saturating integer ALU.
// Used by the front end, the command queue, the back end and the top level.
package sai_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [2:0] {
    CMD_NEG   = 3'd0,
    CMD_ABS   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_MOD   = 3'd4,
    CMD_MAX   = 3'd5,
    CMD_MIN   = 3'd6,
    CMD_CLAMP = 3'd7
  } cmd_t;

  // Work class of a queued transaction.
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2,
    KIND_MOD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  flip;
    logic  b_neg;
  } ctrl_t;

  typedef enum logic [2:0] {
    B_IDLE    = 3'd0,
    B_DIV     = 3'd1,
    B_DIV_END = 3'd2,
    B_MUL     = 3'd3,
    B_MUL_END = 3'd4
  } back_state_t;

endpackage

FILE: src/saturating_integer_alu_unit.sv
// Saturating integer ALU (neg, abs, mul, div, mod, max, min, clamp); done cannot be stalled.
// Single-step commands and special cases are settled in the front end and answered by the
// back end on taking them from the queue; mul and div run the shift-add or restoring loop,
// and mod divides, then multiplies back. The back end takes one transaction at a time and is
// idle again when it raises done, while a two-entry queue keeps accepting start until full, which busy shows.
// Synchronous active-high reset empties the queue and idles the back end.
module saturating_integer_alu_unit #(
  parameter int DATA_WIDTH = sai_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            command,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  input  logic [DATA_WIDTH-1:0] operand_c,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  q_valid;
  sai_pkg::ctrl_t        f_ctrl;
  sai_pkg::ctrl_t        q_ctrl;
  logic [DATA_WIDTH-1:0] f_a;
  logic [DATA_WIDTH-1:0] f_x;
  logic [DATA_WIDTH-1:0] f_y;
  logic [DATA_WIDTH-1:0] q_a;
  logic [DATA_WIDTH-1:0] q_x;
  logic [DATA_WIDTH-1:0] q_y;

  assign busy = full;

  sai_front #(.DW(DATA_WIDTH)) u_front (
    .start     (start),
    .full      (full),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .operand_c (operand_c),
    .push      (push),
    .ctrl      (f_ctrl),
    .a_out     (f_a),
    .x_out     (f_x),
    .y_out     (f_y)
  );

  sai_queue #(.DW(DATA_WIDTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ctrl (f_ctrl),
    .push_a    (f_a),
    .push_x    (f_x),
    .push_y    (f_y),
    .pop       (pop),
    .full      (full),
    .not_empty (q_valid),
    .head_ctrl (q_ctrl),
    .head_a    (q_a),
    .head_x    (q_x),
    .head_y    (q_y)
  );

  sai_back #(.DW(DATA_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ctrl  (q_ctrl),
    .q_a     (q_a),
    .q_x     (q_x),
    .q_y     (q_y),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

FILE: src/sai_front.sv
// Front end of the saturating ALU: accepts a command, settles the simple
// commands and the special cases, and prepares magnitudes for the back end.
// Depends on sai_pkg.
module sai_front #(
  parameter int DW = sai_pkg::DATA_WIDTH_DEF
) (
  input  logic               start,
  input  logic               full,
  input  logic [2:0]         command,
  input  logic [DW-1:0]      operand_a,
  input  logic [DW-1:0]      operand_b,
  input  logic [DW-1:0]      operand_c,
  output logic               push,
  output sai_pkg::ctrl_t     ctrl,
  output logic [DW-1:0]      a_out,
  output logic [DW-1:0]      x_out,
  output logic [DW-1:0]      y_out
);

  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

  logic [DW-1:0] neg_a;
  logic [DW-1:0] neg_b;
  logic [DW-1:0] sat_neg_a;
  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;
  logic [DW-1:0] min_ac;
  logic          b_zero;
  logic          min_by_m1;

  assign push      = start && !full;
  assign neg_a     = '0 - operand_a;
  assign neg_b     = '0 - operand_b;
  assign sat_neg_a = (operand_a == VMIN) ? VMAX : neg_a;
  assign mag_a     = (operand_a == VMIN) ? VMAX : (operand_a[DW-1] ? neg_a : operand_a);
  assign mag_b     = (operand_b == VMIN) ? VMAX : (operand_b[DW-1] ? neg_b : operand_b);
  assign min_ac    = ($signed(operand_a) < $signed(operand_c)) ? operand_a : operand_c;
  assign b_zero    = (operand_b == '0);
  assign min_by_m1 = (operand_a == VMIN) && (operand_b == '1);
  assign a_out     = operand_a;

  always_comb begin
    ctrl.kind  = sai_pkg::KIND_PASS;
    ctrl.flip  = operand_a[DW-1] ^ operand_b[DW-1];
    ctrl.b_neg = operand_b[DW-1];
    x_out      = mag_a;
    y_out      = mag_b;
    case (command)
      sai_pkg::CMD_NEG: begin
        x_out = sat_neg_a;
      end
      sai_pkg::CMD_ABS: begin
        x_out = mag_a;
      end
      sai_pkg::CMD_MUL: begin
        ctrl.kind = sai_pkg::KIND_MUL;
      end
      sai_pkg::CMD_DIV: begin
        if (b_zero) begin
          x_out = '0;
        end else if (min_by_m1) begin
          x_out = VMAX;
        end else begin
          ctrl.kind = sai_pkg::KIND_DIV;
        end
      end
      sai_pkg::CMD_MOD: begin
        if (b_zero || min_by_m1) begin
          x_out = '0;
        end else begin
          ctrl.kind = sai_pkg::KIND_MOD;
        end
      end
      sai_pkg::CMD_MAX: begin
        x_out = ($signed(operand_a) > $signed(operand_b)) ? operand_a : operand_b;
      end
      sai_pkg::CMD_MIN: begin
        x_out = ($signed(operand_a) < $signed(operand_b)) ? operand_a : operand_b;
      end
      sai_pkg::CMD_CLAMP: begin
        x_out = ($signed(operand_b) > $signed(min_ac)) ? operand_b : min_ac;
      end
      default: begin
        x_out = '0;
      end
    endcase
  end

endmodule

FILE: src/sai_queue.sv
// Short command queue between the front end and the back end of the ALU.
// Depends on sai_pkg and the assertion macro header.
`include "saturating_integer_alu_unit_defines.svh"

module sai_queue #(
  parameter int DW = sai_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sai_pkg::ctrl_t     push_ctrl,
  input  logic [DW-1:0]      push_a,
  input  logic [DW-1:0]      push_x,
  input  logic [DW-1:0]      push_y,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output sai_pkg::ctrl_t     head_ctrl,
  output logic [DW-1:0]      head_a,
  output logic [DW-1:0]      head_x,
  output logic [DW-1:0]      head_y
);

  localparam int DEPTH = sai_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);
  localparam logic [PW-1:0]   LAST_P  = PW'(DEPTH - 1);

  sai_pkg::ctrl_t   ent_ctrl [DEPTH];
  logic [DW-1:0]    ent_a    [DEPTH];
  logic [DW-1:0]    ent_x    [DEPTH];
  logic [DW-1:0]    ent_y    [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full      = (count == DEPTH_C);
  assign not_empty = (count != '0);
  assign head_ctrl = ent_ctrl[rd_ptr];
  assign head_a    = ent_a[rd_ptr];
  assign head_x    = ent_x[rd_ptr];
  assign head_y    = ent_y[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_ctrl[wr_ptr] <= push_ctrl;
      ent_a[wr_ptr]    <= push_a;
      ent_x[wr_ptr]    <= push_x;
      ent_y[wr_ptr]    <= push_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  `SAI_CHECK(a_q_no_overflow, !(push && full), "transaction pushed into a full queue")
  `SAI_CHECK(a_q_no_underflow, !(pop && !not_empty), "pop from an empty queue")
  `SAI_CHECK_NEXT(a_q_count_up, push && !pop, count == $past(count) + CNTW'(1), "queue count stuck")

endmodule

FILE: src/sai_back.sv
// Back end of the saturating ALU: shift-add multiplier and restoring divider
// sharing one set of registers, plus sign and remainder fix-up.
// Depends on sai_pkg.
module sai_back #(
  parameter int DW = sai_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sai_pkg::ctrl_t     q_ctrl,
  input  logic [DW-1:0]      q_a,
  input  logic [DW-1:0]      q_x,
  input  logic [DW-1:0]      q_y,
  output logic               pop,
  output logic               done,
  output logic [DW-1:0]      result
);

  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  sai_pkg::back_state_t state;
  sai_pkg::back_state_t state_next;
  sai_pkg::ctrl_t       ctrl;
  sai_pkg::ctrl_t       ctrl_next;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_next;
  logic [DW-1:0]        acc;
  logic [DW-1:0]        acc_next;
  logic [DW-1:0]        x;
  logic [DW-1:0]        x_next;
  logic [DW-1:0]        y;
  logic [DW-1:0]        y_next;
  logic [DW-1:0]        a;
  logic [DW-1:0]        a_next;
  logic [DW-1:0]        result_next;
  logic                 done_next;

  // acc holds the partial remainder while dividing and the product while multiplying.
  logic [DW-1:0] rem_shift;
  logic [DW:0]   rem_diff;
  logic [DW-1:0] quot_signed;
  logic [DW-1:0] mul_res;
  logic [DW-1:0] mod_res;

  assign rem_shift   = {acc[DW-2:0], x[DW-1]};
  assign rem_diff    = {1'b0, rem_shift} - {1'b0, y};
  assign quot_signed = ctrl.flip ? ('0 - x) : x;
  assign mul_res     = ctrl.flip ? ((acc == VMIN) ? VMAX : ('0 - acc)) : acc;
  // Subtracting the saturated negation is an add, except for the most negative product.
  assign mod_res     = ctrl.flip ? ((acc == VMIN) ? (a - VMAX) : (a + acc)) : (a - acc);

  always_comb begin
    state_next = state;
    case (state)
      sai_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_ctrl.kind)
            sai_pkg::KIND_MUL: state_next = sai_pkg::B_MUL;
            sai_pkg::KIND_DIV: state_next = sai_pkg::B_DIV;
            sai_pkg::KIND_MOD: state_next = sai_pkg::B_DIV;
            default:           state_next = sai_pkg::B_IDLE;
          endcase
        end
      end
      sai_pkg::B_DIV: begin
        if (cnt == LAST) begin
          state_next = sai_pkg::B_DIV_END;
        end
      end
      sai_pkg::B_DIV_END: begin
        state_next = (ctrl.kind == sai_pkg::KIND_MOD) ? sai_pkg::B_MUL : sai_pkg::B_IDLE;
      end
      sai_pkg::B_MUL: begin
        if (cnt == LAST) begin
          state_next = sai_pkg::B_MUL_END;
        end
      end
      sai_pkg::B_MUL_END: begin
        state_next = sai_pkg::B_IDLE;
      end
      default: begin
        state_next = sai_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    done_next   = 1'b0;
    result_next = result;
    ctrl_next   = ctrl;
    cnt_next    = cnt;
    acc_next    = acc;
    x_next      = x;
    y_next      = y;
    a_next      = a;
    case (state)
      sai_pkg::B_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          ctrl_next = q_ctrl;
          a_next    = q_a;
          x_next    = q_x;
          y_next    = q_y;
          acc_next  = '0;
          cnt_next  = '0;
          if (q_ctrl.kind == sai_pkg::KIND_PASS) begin
            done_next   = 1'b1;
            result_next = q_x;
          end
        end
      end
      sai_pkg::B_DIV: begin
        cnt_next = cnt + CW'(1);
        if (!rem_diff[DW]) begin
          acc_next = rem_diff[DW-1:0];
          x_next   = {x[DW-2:0], 1'b1};
        end else begin
          acc_next = rem_shift;
          x_next   = {x[DW-2:0], 1'b0};
        end
      end
      sai_pkg::B_DIV_END: begin
        if (ctrl.kind == sai_pkg::KIND_MOD) begin
          // Multiply the quotient magnitude back by the divisor magnitude.
          acc_next       = '0;
          cnt_next       = '0;
          x_next         = y;
          y_next         = x;
          ctrl_next.flip = ctrl.flip ^ ctrl.b_neg;
        end else begin
          done_next   = 1'b1;
          result_next = quot_signed;
        end
      end
      sai_pkg::B_MUL: begin
        cnt_next = cnt + CW'(1);
        acc_next = y[0] ? (acc + x) : acc;
        x_next   = {x[DW-2:0], 1'b0};
        y_next   = {1'b0, y[DW-1:1]};
      end
      sai_pkg::B_MUL_END: begin
        done_next   = 1'b1;
        result_next = (ctrl.kind == sai_pkg::KIND_MOD) ? mod_res : mul_res;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sai_pkg::B_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ctrl   <= ctrl_next;
    acc    <= acc_next;
    x      <= x_next;
    y      <= y_next;
    a      <= a_next;
    result <= result_next;
  end

endmodule

FILE: test/saturating_integer_alu_unit_tb.sv
// Self-checking testbench for the saturating integer ALU: a directed table, then random commands.
// Every transaction's result is predicted here and compared in order of acceptance.
// Depends on sai_pkg and the saturating_integer_alu_unit top level.
`timescale 1ns / 100ps

module saturating_integer_alu_unit_tb;

  localparam int W = sai_pkg::DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_TAIL = 200;
  localparam int DRAIN_LIMIT = 4000;
  localparam int NUM_ROWS = 24;

  typedef logic signed [W-1:0] word_t;

  localparam word_t VMIN = {1'b1, {(W-1){1'b0}}};
  localparam word_t VMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t NEG_VMAX = {1'b1, {(W-2){1'b0}}, 1'b1};

  typedef struct packed {
    sai_pkg::cmd_t op;
    word_t         a;
    word_t         b;
    word_t         c;
    logic          known;
    word_t         want;
  } row_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  logic [2:0]      command;
  logic [W-1:0]    operand_a;
  logic [W-1:0]    operand_b;
  logic [W-1:0]    operand_c;
  logic            done;
  logic [W-1:0]    result;

  word_t pending_results[$];
  int    error_count = 0;
  row_t  directed_rows [0:NUM_ROWS-1];

  saturating_integer_alu_unit #(.DATA_WIDTH(W)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .operand_c(operand_c),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic word_t negate_sat(word_t v);
    return (v == VMIN) ? VMAX : -v;
  endfunction

  function automatic word_t magnitude_sat(word_t v);
    if (v == VMIN) return VMAX;
    return (v < 0) ? -v : v;
  endfunction

  function automatic word_t product_sat(word_t a, word_t b);
    logic [W-1:0] low_bits;
    if (a == 0 || b == 0) return '0;
    low_bits = $unsigned(magnitude_sat(a)) * $unsigned(magnitude_sat(b));
    return (a[W-1] ^ b[W-1]) ? negate_sat(word_t'(low_bits)) : word_t'(low_bits);
  endfunction

  function automatic word_t quotient_sat(word_t a, word_t b);
    logic [W-1:0] q;
    if (b == 0) return '0;
    if (a == VMIN && b == -1) return VMAX;
    q = $unsigned(magnitude_sat(a)) / $unsigned(magnitude_sat(b));
    return (a[W-1] ^ b[W-1]) ? negate_sat(word_t'(q)) : word_t'(q);
  endfunction

  function automatic word_t remainder_sat(word_t a, word_t b);
    if (b == 0) return '0;
    if (a == VMIN && b == -1) return '0;
    return a - product_sat(quotient_sat(a, b), b);
  endfunction

  function automatic word_t larger_of(word_t x, word_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic word_t smaller_of(word_t x, word_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic word_t saturated_result(sai_pkg::cmd_t op, word_t a, word_t b, word_t c);
    case (op)
      sai_pkg::CMD_NEG: return negate_sat(a);
      sai_pkg::CMD_ABS: return magnitude_sat(a);
      sai_pkg::CMD_MUL: return product_sat(a, b);
      sai_pkg::CMD_DIV: return quotient_sat(a, b);
      sai_pkg::CMD_MOD: return remainder_sat(a, b);
      sai_pkg::CMD_MAX: return larger_of(a, b);
      sai_pkg::CMD_MIN: return smaller_of(a, b);
      default: return larger_of(b, smaller_of(a, c));
    endcase
  endfunction

  // Mostly full-range values, with boundary values and small numbers mixed in
  // so that divisions and remainders are not almost always trivial.
  function automatic word_t draw_operand();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 6))
        0: return VMIN;
        1: return VMAX;
        2: return '0;
        3: return word_t'(1);
        4: return word_t'(-1);
        5: return VMIN + 1;
        default: return VMAX - 1;
      endcase
    end
    if (pick < 40) return word_t'($signed($urandom_range(0, 40)) - 20);
    return word_t'($urandom);
  endfunction

  task automatic report_mismatch(string what, word_t want, word_t got);
    error_count++;
    $display("mismatch at %0t ns: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Called just after a rising edge; returns just after the edge that took the transaction.
  task automatic issue_transaction(sai_pkg::cmd_t op, word_t a, word_t b, word_t c,
                                   logic known, word_t want);
    start     <= 1'b1;
    command   <= op;
    operand_a <= a;
    operand_b <= b;
    operand_c <= c;
    do @(posedge clk); while (busy);
    pending_results.push_back(known ? want : saturated_result(op, a, b, c));
  endtask

  task automatic idle_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    word_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding", '0, result);
      end else begin
        want = pending_results.pop_front();
        if (result !== want) report_mismatch("result", want, result);
      end
    end
  end

  initial begin : stimulus
    int            i;
    sai_pkg::cmd_t op;
    word_t         a;
    word_t         b;
    word_t         c;

    directed_rows[0]  = '{sai_pkg::CMD_NEG,   VMIN, 0, 0, 1'b1, VMAX};
    directed_rows[1]  = '{sai_pkg::CMD_NEG,   VMAX, 0, 0, 1'b1, NEG_VMAX};
    directed_rows[2]  = '{sai_pkg::CMD_NEG,   0, 0, 0, 1'b1, 0};
    directed_rows[3]  = '{sai_pkg::CMD_ABS,   VMIN, 0, 0, 1'b1, VMAX};
    directed_rows[4]  = '{sai_pkg::CMD_ABS,   -1, 0, 0, 1'b1, 1};
    directed_rows[5]  = '{sai_pkg::CMD_MUL,   0, VMIN, 0, 1'b1, 0};
    directed_rows[6]  = '{sai_pkg::CMD_MUL,   VMIN, 1, 0, 1'b1, NEG_VMAX};
    directed_rows[7]  = '{sai_pkg::CMD_MUL,   VMAX, VMAX, 0, 1'b0, 0};
    directed_rows[8]  = '{sai_pkg::CMD_MUL,   -3, 7, 0, 1'b0, 0};
    directed_rows[9]  = '{sai_pkg::CMD_MUL,   VMIN, -1, 0, 1'b0, 0};
    directed_rows[10] = '{sai_pkg::CMD_DIV,   5, 0, 0, 1'b1, 0};
    directed_rows[11] = '{sai_pkg::CMD_DIV,   VMIN, -1, 0, 1'b1, VMAX};
    directed_rows[12] = '{sai_pkg::CMD_DIV,   VMIN, 1, 0, 1'b1, NEG_VMAX};
    directed_rows[13] = '{sai_pkg::CMD_DIV,   -7, 2, 0, 1'b0, 0};
    directed_rows[14] = '{sai_pkg::CMD_MOD,   5, 0, 0, 1'b1, 0};
    directed_rows[15] = '{sai_pkg::CMD_MOD,   VMIN, -1, 0, 1'b1, 0};
    directed_rows[16] = '{sai_pkg::CMD_MOD,   -7, 2, 0, 1'b0, 0};
    directed_rows[17] = '{sai_pkg::CMD_MOD,   VMIN, 3, 0, 1'b0, 0};
    directed_rows[18] = '{sai_pkg::CMD_MAX,   VMIN, VMAX, 0, 1'b1, VMAX};
    directed_rows[19] = '{sai_pkg::CMD_MIN,   VMIN, VMAX, 0, 1'b1, VMIN};
    directed_rows[20] = '{sai_pkg::CMD_CLAMP, 5, 10, 0, 1'b1, 10};
    directed_rows[21] = '{sai_pkg::CMD_CLAMP, VMAX, VMIN, VMAX, 1'b1, VMAX};
    directed_rows[22] = '{sai_pkg::CMD_CLAMP, -100, -5, 5, 1'b0, 0};
    directed_rows[23] = '{sai_pkg::CMD_NEG,   1, VMIN, VMAX, 1'b0, 0};

    rst       <= 1'b1;
    start     <= 1'b0;
    command   <= sai_pkg::CMD_NEG;
    operand_a <= '0;
    operand_b <= '0;
    operand_c <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_ROWS; i++) begin
      issue_transaction(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                        directed_rows[i].c, directed_rows[i].known, directed_rows[i].want);
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 8));
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      op = sai_pkg::cmd_t'($urandom_range(0, 7));
      a  = draw_operand();
      b  = draw_operand();
      c  = draw_operand();
      issue_transaction(op, a, b, c, 1'b0, '0);
      // Halfway through, let the block run completely dry once.
      if (i == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 4) == 0) begin
        idle_sender($urandom_range(1, 8));
      end
    end
    start <= 1'b0;

    for (i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++) @(posedge clk);
    repeat (2 * W + 8) @(posedge clk);
    while (pending_results.size() != 0) begin
      report_mismatch("transaction never answered", pending_results.pop_front(), 'x);
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
